/* design/ffha_pkg.sv */
// ffha_pkg: shared constants and codes for the first-fit heap allocator
// granule geometry, status codes, operation codes and register indexes
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int HEADER_BYTES  = 16;
    localparam int ADDR_W        = 32;
    localparam int GRAN_SHIFT    = 3;

    // memory address width, and granule index width that also holds the end marker
    localparam int MEM_AW = $clog2(HEAP_GRANULES);
    localparam int GI_W   = MEM_AW + 1;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_FREED   = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_START = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_END   = 1'b1;

    localparam logic [ADDR_W-1:0] HEAP_END_RESET = 32'd32768;

endpackage

/* design/first_fit_heap_allocator_core.sv */
// path: an allocate with zero or oversized request and a release go through S_PREP and S_OUT to the result
// an allocate also passes S_WALK and S_RESP per free-list entry visited, and S_WALK and S_BUMP when it bumps
// one request at a time: a new request is accepted only once the last result is in the output register
// reset: heap_start 0, heap_end 32768, free list empty, break at heap start
// the size and link memories are not cleared; entries are defined once written
// first_fit_heap_allocator_core: first-fit free-list allocator, depends on ffha_pkg
`timescale 1ns / 1ps

module first_fit_heap_allocator_core
    import ffha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,

    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [31:0]            req_size,
    input  logic [ADDR_W-1:0]      free_addr,

    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ADDR_W-1:0]      result_addr,
    output logic [2:0]             status,
    output logic                   reused
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WALK,
        S_RESP,
        S_BUMP,
        S_OUT
    } state_t;

    localparam logic [GI_W-1:0] END_MARK = GI_W'(HEAP_GRANULES);

    // size and link words, one per granule
    logic [GI_W-1:0] size_mem [HEAP_GRANULES];
    logic [GI_W-1:0] link_mem [HEAP_GRANULES];

    // control and request registers
    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [31:0]         size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [GI_W-1:0]     gr_reg, gr_next;
    logic [GI_W-1:0]     cur_reg, cur_next;
    logic [MEM_AW-1:0]   prev_reg, prev_next;
    logic                has_prev_reg, has_prev_next;
    logic [GI_W-1:0]     steps_reg, steps_next;
    logic [GI_W-1:0]     head_reg, head_next;
    logic [GI_W-1:0]     bump_reg, bump_next;
    logic [ADDR_W-1:0]   hs_reg, hs_next;
    logic [ADDR_W-1:0]   he_reg, he_next;

    // pending result and output register
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_status_reg, res_status_next;
    logic                res_reused_reg, res_reused_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_status_reg, out_status_next;
    logic                out_reused_reg, out_reused_next;

    // memory ports
    logic                rd_en;
    logic [MEM_AW-1:0]   rd_addr;
    logic [GI_W-1:0]     size_q, link_q;
    logic                size_we;
    logic [MEM_AW-1:0]   size_waddr;
    logic [GI_W-1:0]     size_wdata;
    logic                link_we;
    logic [MEM_AW-1:0]   link_waddr;
    logic [GI_W-1:0]     link_wdata;

    // datapath helpers
    logic [32:0]         gr_sum;
    logic [32-GRAN_SHIFT:0] gr_full;
    logic [ADDR_W-1:0]   hdr;
    logic [ADDR_W:0]     off;
    logic                rel_bad;
    logic [GI_W:0]       bump_sum;
    logic [ADDR_W:0]     bump_end;
    logic [ADDR_W-1:0]   cur_uaddr, bump_uaddr;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_addr = out_addr_reg;
    assign status      = out_status_reg;
    assign reused      = out_reused_reg;

    // rounded request in granules, header included
    assign gr_sum  = {1'b0, size_reg} + 33'(HEADER_BYTES + (1 << GRAN_SHIFT) - 1);
    assign gr_full = gr_sum[32:GRAN_SHIFT];

    // release address checks: header offset from heap start must be a granule in range
    assign hdr     = addr_reg - ADDR_W'(HEADER_BYTES);
    assign off     = {1'b0, hdr} - {1'b0, hs_reg};
    assign rel_bad = (addr_reg < ADDR_W'(HEADER_BYTES)) || off[ADDR_W]
                   || (off[GRAN_SHIFT-1:0] != '0)
                   || (off[ADDR_W-1:GRAN_SHIFT+MEM_AW] != '0);

    // break after a bump, and its byte address against the window end
    assign bump_sum = {1'b0, bump_reg} + {1'b0, gr_reg};
    assign bump_end = {1'b0, hs_reg}
                    + (ADDR_W + 1)'({bump_sum, {GRAN_SHIFT{1'b0}}});

    // user addresses lie one header past the block
    assign cur_uaddr  = hs_reg + ADDR_W'({cur_reg, {GRAN_SHIFT{1'b0}}})
                      + ADDR_W'(HEADER_BYTES);
    assign bump_uaddr = hs_reg + ADDR_W'({bump_reg, {GRAN_SHIFT{1'b0}}})
                      + ADDR_W'(HEADER_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        gr_next         = gr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        steps_next      = steps_reg;
        head_next       = head_reg;
        bump_next       = bump_reg;
        hs_next         = hs_reg;
        he_next         = he_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_reused_next = res_reused_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_reused_next = out_reused_reg;

        rd_en      = 1'b0;
        rd_addr    = cur_reg[MEM_AW-1:0];
        size_we    = 1'b0;
        size_waddr = bump_reg[MEM_AW-1:0];
        size_wdata = gr_reg;
        link_we    = 1'b0;
        link_waddr = off[GRAN_SHIFT +: MEM_AW];
        link_wdata = head_reg;

        // configuration writes; to be issued only while idle, which the block itself does not enforce
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HEAP_START: hs_next = cfg_data;
                CFG_HEAP_END:   he_next = cfg_data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    size_next  = req_size;
                    addr_next  = free_addr;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                res_addr_next   = '0;
                res_reused_next = 1'b0;
                state_next      = S_OUT;
                if (op_reg == OP_FREE)
                begin
                    if (addr_reg == '0 || rel_bad)
                    begin
                        res_status_next = ST_IGNORED;
                    end
                    else
                    begin
                        // push onto the head of the free list
                        link_we         = 1'b1;
                        head_next       = {1'b0, off[GRAN_SHIFT +: MEM_AW]};
                        res_status_next = ST_FREED;
                    end
                end
                else if (size_reg == '0)
                begin
                    res_status_next = ST_ZERO;
                end
                else if (gr_full > (33 - GRAN_SHIFT)'(HEAP_GRANULES))
                begin
                    res_status_next = ST_OOM;
                end
                else
                begin
                    gr_next       = gr_full[GI_W-1:0];
                    cur_next      = head_reg;
                    has_prev_next = 1'b0;
                    steps_next    = '0;
                    state_next    = S_WALK;
                end
            end

            S_WALK:
            begin
                // end of list, or walk bound reached on a looping list
                if (steps_reg == END_MARK || cur_reg >= END_MARK)
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (size_q >= gr_reg)
                begin
                    // first fit: unlink whole block
                    if (has_prev_reg)
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_q;
                    end
                    else
                    begin
                        head_next = link_q;
                    end
                    res_addr_next   = cur_uaddr;
                    res_status_next = ST_ALLOC;
                    res_reused_next = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    prev_next     = cur_reg[MEM_AW-1:0];
                    has_prev_next = 1'b1;
                    cur_next      = link_q;
                    steps_next    = steps_reg + 1'b1;
                    state_next    = S_WALK;
                end
            end

            S_BUMP:
            begin
                res_reused_next = 1'b0;
                state_next      = S_OUT;
                if (bump_sum > (GI_W + 1)'(HEAP_GRANULES) || bump_end > {1'b0, he_reg})
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OOM;
                end
                else
                begin
                    size_we         = 1'b1;
                    bump_next       = bump_sum[GI_W-1:0];
                    res_addr_next   = bump_uaddr;
                    res_status_next = ST_ALLOC;
                end
            end

            S_OUT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_reused_next = res_reused_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= END_MARK;
            bump_reg      <= '0;
            hs_reg        <= '0;
            he_reg        <= HEAP_END_RESET;
            out_valid_reg <= 1'b0;
            has_prev_reg  <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            bump_reg      <= bump_next;
            hs_reg        <= hs_next;
            he_reg        <= he_next;
            out_valid_reg <= out_valid_next;
            has_prev_reg  <= has_prev_next;
            steps_reg     <= steps_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        gr_reg         <= gr_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_reused_reg <= res_reused_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_reused_reg <= out_reused_next;
    end

    // size memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (rd_en)
        begin
            size_q <= size_mem[rd_addr];
        end
    end

    // link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en)
        begin
            link_q <= link_mem[rd_addr];
        end
    end

endmodule

/* dv/first_fit_heap_allocator_core_test.sv */
// first_fit_heap_allocator_core_test: self-checking bench for the first-fit heap allocator
// keeps its own allocator state and checks every result transfer in order
// depends on ffha_pkg and first_fit_heap_allocator_core
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_test;
    import ffha_pkg::*;

    // worst case by far is a free-list walk per allocate plus the long receiver hold-off;
    // this bound is several times that, so only a hang reaches it
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;

    // one expected or observed result transfer
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
        logic              reused;
    } heap_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   op        = OP_ALLOC;
    logic [31:0]            req_size  = '0;
    logic [ADDR_W-1:0]      free_addr = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ADDR_W-1:0]      result_addr;
    logic [2:0]             status;
    logic                   reused;

    first_fit_heap_allocator_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .req_size   (req_size),
        .free_addr  (free_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_addr(result_addr),
        .status     (status),
        .reused     (reused)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // allocator state as the bench sees it, at the block's widths but for a wider break
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] heap_base  = '0;
    logic [ADDR_W-1:0] heap_limit = HEAP_END_RESET;
    logic [15:0]       break_gran = '0;
    logic [GI_W-1:0]   free_head_g = GI_W'(HEAP_GRANULES);
    logic [GI_W-1:0]   gran_size [HEAP_GRANULES];
    logic [GI_W-1:0]   gran_link [HEAP_GRANULES];

    // results still owed by the block, oldest first
    heap_result_t pending_results[$];
    // granules of blocks handed out and not yet given back
    int           live_blocks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int results_seen  = 0;
    int n_alloc_new   = 0;
    int n_alloc_reuse = 0;
    int n_refused     = 0;
    int n_oom         = 0;
    int n_freed       = 0;
    int n_ignored     = 0;

    // user address of the block whose header sits at granule g
    function automatic logic [ADDR_W-1:0] user_addr(input int g);
        return heap_base + ADDR_W'(g) * ADDR_W'(8) + ADDR_W'(HEADER_BYTES);
    endfunction

    // granule a release would hand back, or -1 when the block ignores it
    function automatic int release_granule(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] hdr;
        logic [ADDR_W-1:0] off;
        if (addr == '0)
            return -1;
        hdr = addr - ADDR_W'(HEADER_BYTES);
        if (addr < ADDR_W'(HEADER_BYTES) || hdr < heap_base)
            return -1;
        off = hdr - heap_base;
        if (off[GRAN_SHIFT-1:0] != '0 || (off >> GRAN_SHIFT) >= ADDR_W'(HEAP_GRANULES))
            return -1;
        return int'(off >> GRAN_SHIFT);
    endfunction

    // first fit over the free list, no split, else cut at the break
    function automatic heap_result_t alloc_outcome(input logic [31:0] size_b, output int gran);
        heap_result_t r;
        logic [33:0]  need;
        logic [GI_W-1:0] cur;
        logic [GI_W-1:0] prev;
        bit           has_prev;
        int           steps;
        logic [63:0]  break_end;
        r = '{addr: '0, status: ST_ALLOC, reused: 1'b0};
        gran = -1;
        if (size_b == '0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        need = ({2'b00, size_b} + 34'(HEADER_BYTES) + 34'd7) >> GRAN_SHIFT;
        if (need > 34'(HEAP_GRANULES))
        begin
            r.status = ST_OOM;
            return r;
        end
        cur = free_head_g;
        prev = '0;
        has_prev = 1'b0;
        steps = 0;
        // a looping list is cut off after one pass worth of entries
        while (steps < HEAP_GRANULES && cur < GI_W'(HEAP_GRANULES))
        begin
            if (34'(gran_size[int'(cur)]) >= need)
            begin
                if (has_prev)
                    gran_link[int'(prev)] = gran_link[int'(cur)];
                else
                    free_head_g = gran_link[int'(cur)];
                r.addr = user_addr(int'(cur));
                r.reused = 1'b1;
                gran = int'(cur);
                return r;
            end
            prev = cur;
            has_prev = 1'b1;
            cur = gran_link[int'(cur)];
            steps++;
        end
        break_end = 64'(heap_base) + (64'(break_gran) + 64'(need)) * 64'd8;
        if (64'(break_gran) + 64'(need) > 64'(HEAP_GRANULES) || break_end > 64'(heap_limit))
        begin
            r.status = ST_OOM;
            return r;
        end
        gran = int'(break_gran);
        gran_size[gran] = GI_W'(need);
        r.addr = user_addr(gran);
        break_gran = break_gran + 16'(need);
        return r;
    endfunction

    // push onto the list head, no coalescing
    function automatic heap_result_t release_outcome(input logic [ADDR_W-1:0] addr);
        heap_result_t r;
        int           g;
        r = '{addr: '0, status: ST_IGNORED, reused: 1'b0};
        g = release_granule(addr);
        if (g >= 0)
        begin
            gran_link[g] = free_head_g;
            free_head_g = GI_W'(g);
            r.status = ST_FREED;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and the result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transfer", result_addr, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result_addr !== want.addr)
                    report_mismatch("result_addr", result_addr, want.addr);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (reused !== want.reused)
                    report_mismatch("reused", 32'(reused), 32'(want.reused));
                case (want.status)
                    ST_ALLOC:
                        if (want.reused)
                            n_alloc_reuse++;
                        else
                            n_alloc_new++;
                    ST_ZERO:    n_refused++;
                    ST_OOM:     n_oom++;
                    ST_FREED:   n_freed++;
                    default:    n_ignored++;
                endcase
            end
            results_seen++;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
        out_ready = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // register write; only called with the block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_HEAP_START)
            heap_base = data;
        else
            heap_limit = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one request transfer; the expectation is formed at the accepting edge
    task automatic issue(input logic op_i, input logic [31:0] size_i,
                         input logic [ADDR_W-1:0] addr_i,
                         output heap_result_t res, output int gran);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        op        = op_i;
        req_size  = size_i;
        free_addr = addr_i;
        do
            @(posedge clk);
        while (!in_ready);
        gran = -1;
        if (op_i == OP_ALLOC)
            res = alloc_outcome(size_i, gran);
        else
            res = release_outcome(addr_i);
        pending_results.push_back(res);
    endtask

    // drop valid and let every owed result come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic alloc_bytes(input logic [31:0] size_b);
        heap_result_t r;
        int           g;
        // free_addr is don't-care on an allocate, so it carries noise
        issue(OP_ALLOC, size_b, $urandom(), r, g);
        if (g >= 0)
            live_blocks.push_back(g);
    endtask

    // give back a live block; near the top of the address space it may wrap and be ignored
    task automatic release_live(input int idx);
        heap_result_t r;
        int           g;
        int           gd;
        logic [ADDR_W-1:0] a;
        g = live_blocks[idx];
        a = user_addr(g);
        if (release_granule(a) == g)
            live_blocks.delete(idx);
        issue(OP_FREE, $urandom(), a, r, gd);
    endtask

    // arbitrary address; one that would free a block not handed out becomes null
    task automatic release_raw(input logic [ADDR_W-1:0] addr);
        heap_result_t r;
        int           g;
        int           gd;
        int           hit;
        logic [ADDR_W-1:0] a;
        a = addr;
        g = release_granule(a);
        if (g >= 0)
        begin
            hit = -1;
            foreach (live_blocks[k])
                if (live_blocks[k] == g)
                    hit = k;
            if (hit >= 0)
                live_blocks.delete(hit);
            else
                a = '0;
        end
        issue(OP_FREE, $urandom(), a, r, gd);
    endtask

    // mostly small blocks so the heap cycles through many of them
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(64, 1);
        else if (r < 96)
            return $urandom_range(512, 65);
        return $urandom_range(4096, 513);
    endfunction

    // random traffic: mostly alloc/free of real blocks, some refusals and stray frees
    task automatic run_traffic(input int n_items);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < 48 || (r < 84 && live_blocks.size() == 0))
                alloc_bytes(pick_size());
            else if (r < 84)
                release_live($urandom_range(live_blocks.size() - 1));
            else if (r < 89)
                alloc_bytes(($urandom_range(3) == 0) ? 32'd0 : $urandom());
            else if (r < 95)
                release_raw(($urandom_range(3) == 0) ? '0 : ADDR_W'($urandom()));
            else if (live_blocks.size() != 0)
                // off the granule grid
                release_raw(user_addr(live_blocks[$urandom_range(live_blocks.size() - 1)])
                            + ADDR_W'($urandom_range(7, 1)));
            else
                release_raw(ADDR_W'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // edge sizes, first fit with and without a predecessor, refusals, stray frees
    task automatic test_directed();
        int g_a;
        int g_d;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_HEAP_START, '0);
        write_reg(CFG_HEAP_END, HEAP_END_RESET);
        alloc_bytes(32'd0);             // zero size refused
        alloc_bytes(32'hFFFF_FFFF);     // huge size
        alloc_bytes(32'd32753);         // one granule over capacity after header
        alloc_bytes(32'd1);
        alloc_bytes(32'd8);
        alloc_bytes(32'd9);
        alloc_bytes(32'd100);
        g_a = live_blocks[0];
        g_d = live_blocks[3];
        release_raw('0);                                // null release
        release_raw(ADDR_W'(8));                        // header below window start
        release_raw(user_addr(g_a) + ADDR_W'(4));       // off the granule grid
        release_raw(user_addr(HEAP_GRANULES));          // past the last granule
        release_live(3);                                // list: d
        release_live(0);                                // list: a -> d
        alloc_bytes(32'd50);            // a too small, d taken behind it
        alloc_bytes(32'd9);             // a still too small, bump
        alloc_bytes(32'd8);             // a taken from the head
        alloc_bytes(32'd32752);         // exactly the capacity, break already past
        wait_idle();
        // no room: window closed
        write_reg(CFG_HEAP_END, '0);
        alloc_bytes(32'd1000);
        wait_idle();
        write_reg(CFG_HEAP_START, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
        alloc_bytes(32'd1);
        release_raw(32'hFFFF_FFFF);
        release_raw(ADDR_W'(15));
        wait_idle();
        if (g_d < 0)
            $display("unreachable");
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct,
                                     input logic [ADDR_W-1:0] base,
                                     input logic [ADDR_W-1:0] limit, input int n_items);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_HEAP_START, base);
        write_reg(CFG_HEAP_END, limit);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        run_traffic(n_items);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_req = hold_req + 1;
        run_traffic(30);
        wait_idle();
    endtask

    // break past capacity with heap_end wide open
    task automatic test_capacity();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_HEAP_START, '0);
        write_reg(CFG_HEAP_END, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            alloc_bytes(32'd4000);
        alloc_bytes(32'd32752);
        wait_idle();
    endtask

    // freeing the same block twice loops the list; the walk must give up and fall back
    task automatic test_looping_list();
        heap_result_t r;
        int           g;
        int           gd;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (live_blocks.size() == 0)
            alloc_bytes(32'd8);
        if (live_blocks.size() != 0)
        begin
            g = live_blocks[0];
            release_live(0);
            issue(OP_FREE, $urandom(), user_addr(g), r, gd);
            alloc_bytes(32'(gran_size[g]) * 32'd8);     // too big for the loop
            alloc_bytes(32'd1);                         // fits the looped block
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_phase(28, 54, 32'h0001_0000, 32'h0001_8000, 210);
        test_random_phase(54, 28, 32'hFFFF_8000, 32'hFFFF_FFFF, 210);
        test_random_phase(0, 0, 32'h0000_0007, 32'h0000_4000, 210);
        test_backpressure();
        test_capacity();
        test_looping_list();

        // tail: anything still owed after a generous wait is a failure
        for (int i = 0; i < DRAIN_CYCLES && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 32'(pending_results.size()), '0);

        $display("covered %0d results: %0d fresh blocks, %0d reused, %0d out of memory",
                 results_seen, n_alloc_new, n_alloc_reuse, n_oom);
        $display("  %0d zero-size refusals, %0d frees, %0d ignored frees, %0d mismatches",
                 n_refused, n_freed, n_ignored, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
